// ----- src/hsos_pkg.sv -----
// ----------------------------------------------------------------------------
// hsos_pkg
// Shared types, constants and helpers of the slope and occupancy stencil.
// ----------------------------------------------------------------------------
package hsos_pkg;

  localparam int MAX_ROW_WIDTH = 1024;
  localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
  localparam int RW_W          = 11;
  localparam int H_W           = 20;
  localparam int DIV_W         = 24;

  localparam logic [2:0] CFG_ROW_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_SMOOTH_EN   = 3'd1;
  localparam logic [2:0] CFG_PROB_MODE   = 3'd2;
  localparam logic [2:0] CFG_SLOPE_THR   = 3'd3;
  localparam logic [2:0] CFG_RAMP_GAIN   = 3'd4;
  localparam logic [2:0] CFG_MIN_NEIGHB  = 3'd5;

  typedef struct packed {
    logic                  v;
    logic signed [H_W-1:0] h;
  } cell_t;

  typedef struct packed {
    cell_t row1;
    cell_t row0;
  } line_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [3:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [3:0]       remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_SUM, ST_SDIV, ST_SHIFT2,
    ST_ACC, ST_GDIV, ST_MUL, ST_OUT
  } state_t;

  // A valid cell in window column c is usable unless it falls off the left or right row edge.
  function automatic logic usable(input logic [1:0] c, input logic [COL_W-1:0] cc,
                                  input logic [RW_W-1:0] w, input logic v);
    logic ok;
    ok = v;
    if (c == 2'd0 && cc == '0) ok = 1'b0;
    if (c == 2'd2 && ({1'b0, cc} + RW_W'(1)) >= w) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- src/hsos_if.sv -----
// ----------------------------------------------------------------------------
// hsos channel interfaces
// Valid/ready channels for cells, results and configuration writes.
// ----------------------------------------------------------------------------
interface hsos_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [19:0]       cell_height;
  logic                     height_valid;
  modport source (output valid, cell_height, height_valid, input ready);
  modport sink (input valid, cell_height, height_valid, output ready);
endinterface

interface hsos_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] occupancy;
  logic [15:0]       slope;
  logic [3:0]        neighbor_count;
  logic              center_valid;
  modport source (output valid, occupancy, slope, neighbor_count, center_valid,
                  input ready);
  modport sink (input valid, occupancy, slope, neighbor_count, center_valid,
                output ready);
endinterface

interface hsos_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [22:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/hsos_div.sv -----
// ----------------------------------------------------------------------------
// hsos_div
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
// ----------------------------------------------------------------------------
module hsos_div (
  input  logic               clk,
  input  logic               rst_n,
  input  hsos_pkg::div_req_t req,
  output hsos_pkg::div_rsp_t rsp
);

  logic [hsos_pkg::DIV_W-1:0] dq_r, dq_nxt;
  logic [3:0]                 rem_r, rem_nxt;
  logic [3:0]                 dsr_r;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [4:0]                 trial;

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dq_r[hsos_pkg::DIV_W-1]};
    if (req.start) begin
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = 5'(hsos_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 4'(trial - {1'b0, dsr_r});
        dq_nxt  = {dq_r[hsos_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[3:0];
        dq_nxt  = {dq_r[hsos_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (req.start) dsr_r <= req.divisor;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- src/height_slope_occupancy_stencil_unit.sv -----
// ----------------------------------------------------------------------------
// height_slope_occupancy_stencil_unit
// 3x3 slope traversability filter over a raster stream of height cells.
// ----------------------------------------------------------------------------
// Cells enter on in_if in raster order, one transaction per cell. Each cell
// yields one result transaction on out_if, which describes the cell that
// entered 2*W+2 cells earlier, W being the effective row width. Registers are
// written on cfg_if, which is always ready; write them only while idle.
// One cell is processed at a time. Its processing time is set by the
// serial 9-tap window sweeps of both stencil stages and the shared
// bit-serial divider used for the smoothing mean and the slope mean, and
// is shortest with an invalid center and smoothing off. Line stores live
// in two single-port memories with registered reads, with one read and
// one write per cell each.
// After reset the unit clears every entry of both line stores, with
// in_if.ready low; configuration writes are taken meanwhile. A finished
// result sits in an output register; the next cell is accepted while it
// waits, and a second result waits until out_if.ready takes the first.
// ----------------------------------------------------------------------------
module height_slope_occupancy_stencil_unit (
  input  logic       clk,
  input  logic       rst_n,
  hsos_in_if.sink    in_if,
  hsos_out_if.source out_if,
  hsos_cfg_if.sink   cfg_if
);

  localparam int CW = hsos_pkg::COL_W;

  hsos_pkg::line_t raw_mem [hsos_pkg::MAX_ROW_WIDTH];
  hsos_pkg::line_t sm_mem  [hsos_pkg::MAX_ROW_WIDTH];
  hsos_pkg::line_t raw_rd_r, sm_rd_r;

  hsos_pkg::cell_t raw_win_r [3][3];
  hsos_pkg::cell_t sm_win_r  [3][3];

  hsos_pkg::state_t state_r, state_nxt;

  logic [10:0] row_width_r;
  logic        smooth_en_r, prob_mode_r;
  logic [15:0] slope_thr_r;
  logic [22:0] ramp_gain_r;
  logic [3:0]  min_nb_r;

  logic [CW-1:0] cc_r, col_r, cc1_r, cc2_r, clr_r;
  logic [CW-1:0] col_c, cc1_c, cc2_c;
  logic [10:0]   w_eff;
  hsos_pkg::cell_t cell_r, mid_r;

  logic [1:0]  ri_r, ci_r;
  logic        last_pos;
  logic signed [23:0] sum_r, sum_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [15:0] slope_r;
  logic        cv_r;
  logic [38:0] prod_r;
  logic [23:0] sum_mag;
  logic [23:0] q_up;

  hsos_pkg::cell_t scell, ctr;
  logic signed [20:0] diff;
  logic [20:0]  adiff;
  logic [31:0]  wdiff;

  hsos_pkg::div_req_t div_req_r;
  hsos_pkg::div_rsp_t div_rsp;

  logic signed [7:0] out_occ_r, occ_c;
  logic [15:0] out_slope_r;
  logic [3:0]  out_n_r;
  logic        out_cv_r, out_valid_r;

  logic in_acc, out_load, mem_we;
  logic [CW-1:0] raw_wa, sm_wa;
  hsos_pkg::line_t raw_wd, sm_wd;
  logic raw_we, sm_we;

  hsos_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .rsp(div_rsp));

  // Configuration registers.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= 11'd256;
      smooth_en_r <= 1'b0;
      prob_mode_r <= 1'b0;
      slope_thr_r <= 16'd256;
      ramp_gain_r <= 23'd25600;
      min_nb_r    <= 4'd0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        hsos_pkg::CFG_ROW_WIDTH:  row_width_r <= cfg_if.data[10:0];
        hsos_pkg::CFG_SMOOTH_EN:  smooth_en_r <= cfg_if.data[0];
        hsos_pkg::CFG_PROB_MODE:  prob_mode_r <= cfg_if.data[0];
        hsos_pkg::CFG_SLOPE_THR:  slope_thr_r <= cfg_if.data[15:0];
        hsos_pkg::CFG_RAMP_GAIN:  ramp_gain_r <= cfg_if.data;
        hsos_pkg::CFG_MIN_NEIGHB: min_nb_r    <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_width_r == '0) w_eff = 11'd1;
    else if (row_width_r > 11'(hsos_pkg::MAX_ROW_WIDTH)) w_eff = 11'(hsos_pkg::MAX_ROW_WIDTH);
    else w_eff = row_width_r;
    col_c = ({1'b0, cc_r} >= w_eff) ? '0 : cc_r;
    cc1_c = (col_c == '0) ? CW'(w_eff - 11'd1) : col_c - CW'(1);
    cc2_c = (cc1_c == '0) ? CW'(w_eff - 11'd1) : cc1_c - CW'(1);
  end

  assign in_if.ready = (state_r == hsos_pkg::ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign last_pos    = (ri_r == 2'd2) && (ci_r == 2'd2);
  assign out_load    = (state_r == hsos_pkg::ST_OUT) && (!out_valid_r || out_if.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsos_pkg::ST_CLEAR: if (clr_r == CW'(hsos_pkg::MAX_ROW_WIDTH - 1))
                            state_nxt = hsos_pkg::ST_IDLE;
      hsos_pkg::ST_IDLE:  if (in_acc) state_nxt = hsos_pkg::ST_LOAD;
      hsos_pkg::ST_LOAD: begin
        if (smooth_en_r && raw_win_r[1][2].v) state_nxt = hsos_pkg::ST_SUM;
        else state_nxt = hsos_pkg::ST_SHIFT2;
      end
      hsos_pkg::ST_SUM:   if (last_pos) state_nxt = hsos_pkg::ST_SDIV;
      hsos_pkg::ST_SDIV:  if (div_rsp.done) state_nxt = hsos_pkg::ST_SHIFT2;
      hsos_pkg::ST_SHIFT2: begin
        if (sm_win_r[1][2].v) state_nxt = hsos_pkg::ST_ACC;
        else state_nxt = hsos_pkg::ST_MUL;
      end
      hsos_pkg::ST_ACC: begin
        if (last_pos) state_nxt = (n_nxt == '0) ? hsos_pkg::ST_MUL : hsos_pkg::ST_GDIV;
      end
      hsos_pkg::ST_GDIV:  if (div_rsp.done) state_nxt = hsos_pkg::ST_MUL;
      hsos_pkg::ST_MUL:   state_nxt = hsos_pkg::ST_OUT;
      hsos_pkg::ST_OUT:   if (out_load) state_nxt = hsos_pkg::ST_IDLE;
      default:            state_nxt = hsos_pkg::ST_CLEAR;
    endcase
  end

  // Datapath combinational terms.
  always_comb begin
    scell   = raw_win_r[ri_r][ci_r];
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (hsos_pkg::usable(ci_r, cc1_r, w_eff, scell.v)) begin
      sum_nxt = sum_r + 24'(scell.h);
      cnt_nxt = cnt_r + 4'd1;
    end
    sum_mag = sum_nxt[23] ? 24'(-sum_nxt) : sum_nxt;
    q_up    = div_rsp.quotient + ((div_rsp.remainder != '0) ? 24'd1 : 24'd0);

    ctr   = sm_win_r[1][1];
    diff  = 21'(sm_win_r[ri_r][ci_r].h) - 21'(ctr.h);
    adiff = diff[20] ? 21'(-diff) : 21'(diff);
    wdiff = ((ri_r != 2'd1) && (ci_r != 2'd1)) ? 32'(adiff) * 32'd181
                                                : {3'b0, adiff, 8'b0};
    acc_nxt = acc_r;
    n_nxt   = n_r;
    if (!((ri_r == 2'd1) && (ci_r == 2'd1)) &&
        hsos_pkg::usable(ci_r, cc2_r, w_eff, sm_win_r[ri_r][ci_r].v)) begin
      acc_nxt = acc_r + wdiff;
      n_nxt   = n_r + 4'd1;
    end
  end

  // Occupancy from the registered slope and ramp product.
  always_comb begin
    if (!cv_r || n_r < min_nb_r) occ_c = -8'sd1;
    else if (slope_r >= slope_thr_r) occ_c = 8'sd100;
    else if (prob_mode_r) occ_c = (prod_r[38:16] > 23'd100) ? 8'sd100 : 8'(prod_r[22:16]);
    else occ_c = 8'sd0;
  end

  // Memory write port selection.
  always_comb begin
    mem_we = (state_r == hsos_pkg::ST_CLEAR);
    raw_we = mem_we || (state_r == hsos_pkg::ST_LOAD);
    sm_we  = mem_we || (state_r == hsos_pkg::ST_SHIFT2);
    raw_wa = mem_we ? clr_r : col_r;
    sm_wa  = mem_we ? clr_r : cc1_r;
    raw_wd = mem_we ? '0 : {raw_rd_r.row0, cell_r};
    sm_wd  = mem_we ? '0 : {sm_rd_r.row0, mid_r};
  end

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_wa] <= raw_wd;
    if (sm_we) sm_mem[sm_wa] <= sm_wd;
    if (in_acc) begin
      raw_rd_r <= raw_mem[col_c];
      sm_rd_r  <= sm_mem[cc1_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsos_pkg::ST_CLEAR;
      clr_r       <= '0;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          raw_win_r[r][c] <= '0;
          sm_win_r[r][c]  <= '0;
        end
      end
    end else begin
      state_r         <= state_nxt;
      div_req_r.start <= (state_r == hsos_pkg::ST_SUM && last_pos) ||
                         (state_r == hsos_pkg::ST_ACC && last_pos && n_nxt != '0);
      if (state_r == hsos_pkg::ST_CLEAR) clr_r <= clr_r + CW'(1);
      if (in_acc) cc_r <= ({1'b0, col_c} + 11'd1 >= w_eff) ? '0 : col_c + CW'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
      if (state_r == hsos_pkg::ST_LOAD) begin
        for (int r = 0; r < 3; r++) begin
          raw_win_r[r][0] <= raw_win_r[r][1];
          raw_win_r[r][1] <= raw_win_r[r][2];
        end
        raw_win_r[0][2] <= raw_rd_r.row1;
        raw_win_r[1][2] <= raw_rd_r.row0;
        raw_win_r[2][2] <= cell_r;
      end
      if (state_r == hsos_pkg::ST_SHIFT2) begin
        for (int r = 0; r < 3; r++) begin
          sm_win_r[r][0] <= sm_win_r[r][1];
          sm_win_r[r][1] <= sm_win_r[r][2];
        end
        sm_win_r[0][2] <= sm_rd_r.row1;
        sm_win_r[1][2] <= sm_rd_r.row0;
        sm_win_r[2][2] <= mid_r;
      end
      if (state_r == hsos_pkg::ST_SUM && last_pos) begin
        div_req_r.dividend <= sum_mag;
        div_req_r.divisor  <= cnt_nxt;
      end
      if (state_r == hsos_pkg::ST_ACC && last_pos && n_nxt != '0) begin
        div_req_r.dividend <= acc_nxt[31:8];
        div_req_r.divisor  <= n_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_r <= {in_if.height_valid, in_if.cell_height};
      col_r  <= col_c;
      cc1_r  <= cc1_c;
      cc2_r  <= cc2_c;
    end
    case (state_r)
      hsos_pkg::ST_LOAD: begin
        mid_r <= raw_win_r[1][2];
        ri_r  <= '0;
        ci_r  <= '0;
        sum_r <= '0;
        cnt_r <= '0;
      end
      hsos_pkg::ST_SUM: begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        ci_r  <= (ci_r == 2'd2) ? 2'd0 : ci_r + 2'd1;
        if (ci_r == 2'd2) ri_r <= ri_r + 2'd1;
      end
      hsos_pkg::ST_SDIV: begin
        if (div_rsp.done)
          mid_r.h <= sum_r[23] ? 20'(-q_up) : div_rsp.quotient[19:0];
      end
      hsos_pkg::ST_SHIFT2: begin
        cv_r    <= sm_win_r[1][2].v;
        ri_r    <= '0;
        ci_r    <= '0;
        acc_r   <= '0;
        n_r     <= '0;
        slope_r <= '0;
      end
      hsos_pkg::ST_ACC: begin
        acc_r <= acc_nxt;
        n_r   <= n_nxt;
        ci_r  <= (ci_r == 2'd2) ? 2'd0 : ci_r + 2'd1;
        if (ci_r == 2'd2) ri_r <= ri_r + 2'd1;
      end
      hsos_pkg::ST_GDIV: begin
        if (div_rsp.done)
          slope_r <= (div_rsp.quotient[23:16] != '0) ? 16'hFFFF : div_rsp.quotient[15:0];
      end
      hsos_pkg::ST_MUL: prod_r <= 39'(slope_r) * 39'(ramp_gain_r);
      default: ;
    endcase
    if (out_load) begin
      out_occ_r   <= occ_c;
      out_slope_r <= cv_r ? slope_r : '0;
      out_n_r     <= cv_r ? n_r : '0;
      out_cv_r    <= cv_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.occupancy      = out_occ_r;
  assign out_if.slope          = out_slope_r;
  assign out_if.neighbor_count = out_n_r;
  assign out_if.center_valid   = out_cv_r;

`ifndef ASSERT_OFF
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == hsos_pkg::ST_LOAD)
    else $error("accepted cell did not enter the load step");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req_r.start |-> (state_r == hsos_pkg::ST_SDIV || state_r == hsos_pkg::ST_GDIV))
    else $error("divider started outside a divide step");
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_n_r <= 4'd8)
    else $error("neighbor count above eight");
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == hsos_pkg::ST_OUT))
    else $error("result raised outside the output step");
`endif

endmodule
